### design/tsom_pkg.sv
// ----------------------------------------------------------------------------
// tsom_pkg
// Shared types and constants for the three-stack core: field widths,
// opcode and status codes, and the control structs between the core and
// its stacks.
// ----------------------------------------------------------------------------
package tsom_pkg;

   localparam int NUM_STACKS_DEF      = 3;
   localparam int PER_STACK_DEPTH_DEF = 16;
   localparam int DATA_WIDTH_DEF      = 32;

   localparam int SEL_WIDTH   = 2;
   localparam int VALUE_WIDTH = 32;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_STACK = 2'd3
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } stack_flags_type;

endpackage

### design/tsom_cell.sv
// ----------------------------------------------------------------------------
// tsom_cell
// One entry of a shift-register stack. On a push it takes the entry above
// it, on a pop the entry below it, otherwise it holds.
// ----------------------------------------------------------------------------
module tsom_cell #(
   parameter int DATA_WIDTH = tsom_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  tsom_pkg::shift_cmd_type cmd,
   input  logic [DATA_WIDTH-1:0]   from_above,
   input  logic [DATA_WIDTH-1:0]   from_below,
   output logic [DATA_WIDTH-1:0]   value
);
   import tsom_pkg::*;

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.push) begin
         value_in = from_above;
      end else if (cmd.pop) begin
         value_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### design/tsom_stack.sv
// ----------------------------------------------------------------------------
// tsom_stack
// One LIFO stack built as a chain of cells. The top of stack is always the
// first cell; a fill count gives the full and empty flags.
// ----------------------------------------------------------------------------
module tsom_stack #(
   parameter int DEPTH      = tsom_pkg::PER_STACK_DEPTH_DEF,
   parameter int DATA_WIDTH = tsom_pkg::DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsom_pkg::shift_cmd_type   cmd,
   input  logic [DATA_WIDTH-1:0]     push_data,
   output logic [DATA_WIDTH-1:0]     top_data,
   output tsom_pkg::stack_flags_type flags
);
   import tsom_pkg::*;

   localparam int CountW = $clog2(DEPTH + 1);

   logic [CountW-1:0]     count_ff;
   logic [CountW-1:0]     count_in;
   logic [DATA_WIDTH-1:0] link [0:DEPTH];

   assign link[0] = push_data;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] below;
      if (i == DEPTH - 1) begin : g_last
         assign below = link[i+1];
      end else begin : g_mid
         assign below = link[i+2];
      end
      tsom_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .from_above(link[i]),
         .from_below(below),
         .value     (link[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CountW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_data    = link[1];
   assign flags.full  = (count_ff == CountW'(DEPTH));
   assign flags.empty = (count_ff == '0);

endmodule

### design/three_stacks_one_memory_core.sv
// ----------------------------------------------------------------------------
// three_stacks_one_memory_core
// Several LIFO stacks of equal fixed depth, each a chain of shift cells.
// ----------------------------------------------------------------------------
// Each transaction (push or pop to one stack) is taken when start is high and
// busy is low, and gives exactly one result on rsp_pop_value / rsp_status,
// marked by rsp_valid for one cycle, in the cycle after it was taken. A new
// transaction can be taken every cycle while busy is low: the whole stack
// moves by one cell in one update of the cell chain. busy is high only
// during reset and the cycle after it. There is no way to hold results
// off; the receiver must take rsp_valid when it appears.
// ----------------------------------------------------------------------------
module three_stacks_one_memory_core #(
   parameter int NUM_STACKS      = tsom_pkg::NUM_STACKS_DEF,
   parameter int PER_STACK_DEPTH = tsom_pkg::PER_STACK_DEPTH_DEF,
   parameter int DATA_WIDTH      = tsom_pkg::DATA_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_opcode,
   input  logic [tsom_pkg::SEL_WIDTH-1:0]           req_stack_select,
   input  logic signed [tsom_pkg::VALUE_WIDTH-1:0]  req_push_value,
   output logic                                     rsp_valid,
   output logic signed [tsom_pkg::VALUE_WIDTH-1:0]  rsp_pop_value,
   output logic [1:0]                               rsp_status
);
   import tsom_pkg::*;

   logic                          busy_ff;
   logic                          rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_pop_value_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_pop_value_in;
   status_type                    rsp_status_ff;
   status_type                    rsp_status_in;

   logic                          accept;
   logic                          sel_ok;
   logic [DATA_WIDTH-1:0]         push_data;
   logic signed [DATA_WIDTH-1:0]  sel_top;
   stack_flags_type               sel_flags;

   shift_cmd_type                 cmd   [NUM_STACKS];
   stack_flags_type               flags [NUM_STACKS];
   logic [DATA_WIDTH-1:0]         top   [NUM_STACKS];

   assign accept    = start && !busy_ff;
   assign sel_ok    = (req_stack_select < SEL_WIDTH'(NUM_STACKS));
   assign push_data = DATA_WIDTH'(req_push_value);

   for (genvar s = 0; s < NUM_STACKS; s++) begin : g_stack
      logic hit;
      assign hit          = accept && (req_stack_select == SEL_WIDTH'(s));
      assign cmd[s].push  = hit && (req_opcode == OP_PUSH) && !flags[s].full;
      assign cmd[s].pop   = hit && (req_opcode == OP_POP) && !flags[s].empty;

      tsom_stack #(
         .DEPTH     (PER_STACK_DEPTH),
         .DATA_WIDTH(DATA_WIDTH)
      ) u_stack (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd[s]),
         .push_data(push_data),
         .top_data (top[s]),
         .flags    (flags[s])
      );
   end

   always_comb begin
      sel_top   = '0;
      sel_flags = '0;
      for (int s = 0; s < NUM_STACKS; s++) begin
         if (req_stack_select == SEL_WIDTH'(s)) begin
            sel_top   = top[s];
            sel_flags = flags[s];
         end
      end
   end

   always_comb begin
      rsp_pop_value_in = '0;
      rsp_status_in    = ST_OK;
      if (!sel_ok) begin
         rsp_status_in = ST_BAD_STACK;
      end else if (req_opcode == OP_PUSH) begin
         if (sel_flags.full) begin
            rsp_status_in = ST_FULL;
         end
      end else begin
         if (sel_flags.empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_pop_value_in = VALUE_WIDTH'(sel_top);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
      if (accept) begin
         rsp_pop_value_ff <= rsp_pop_value_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

### design/tsom_checker.sv
// ----------------------------------------------------------------------------
// tsom_checker
// Port-level checks on the three-stack core, bound to the top level.
// ----------------------------------------------------------------------------
module tsom_checker #(
   parameter int NUM_STACKS = tsom_pkg::NUM_STACKS_DEF
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    start,
   input logic                                    busy,
   input logic                                    req_opcode,
   input logic [tsom_pkg::SEL_WIDTH-1:0]          req_stack_select,
   input logic                                    rsp_valid,
   input logic signed [tsom_pkg::VALUE_WIDTH-1:0] rsp_pop_value,
   input logic [1:0]                              rsp_status
);
   import tsom_pkg::*;

   logic accept;
   assign accept = start && !busy;

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("transaction gave no result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result without a transaction");

   a_push_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_PUSH) |=> (rsp_pop_value == '0))
      else $error("push returned nonzero value");

   a_bad_stack: assert property (@(posedge clock) disable iff (reset)
      (accept && req_stack_select >= SEL_WIDTH'(NUM_STACKS))
      |=> (rsp_status == ST_BAD_STACK))
      else $error("bad stack number not flagged");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_pop_value == '0))
      else $error("failed transaction returned nonzero value");

endmodule

bind three_stacks_one_memory_core tsom_checker #(
   .NUM_STACKS(NUM_STACKS)
) u_tsom_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_opcode      (req_opcode),
   .req_stack_select(req_stack_select),
   .rsp_valid       (rsp_valid),
   .rsp_pop_value   (rsp_pop_value),
   .rsp_status      (rsp_status)
);
